>>> rtl/core/button_gesture_decoder_assert.svh
// Assertion macros used by the button gesture decoder RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef BUTTON_GESTURE_DECODER_ASSERT_SVH
`define BUTTON_GESTURE_DECODER_ASSERT_SVH

// Same-cycle check: when ante holds, cons must hold too.
`define BGD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define BGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bgd_pkg.sv
// Shared types and constants for the button gesture decoder.
// No dependencies; used by every module under rtl/core.
package bgd_pkg;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned TAP_W      = 4;
    localparam int unsigned BANK_W     = 2;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_SAT  = 16'hFFFF;
    localparam logic [TAP_W-1:0]  TAP_SAT   = 4'd15;
    localparam logic [BANK_W-1:0] BANK_LAST = 2'd2;
    localparam logic [BANK_W-1:0] BANK_RST  = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MIN      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_DELAY = 8'd3;

    localparam logic [TICK_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [TICK_W-1:0] TAP_MIN_RST      = 16'd50;
    localparam logic [TICK_W-1:0] TAP_MAX_RST      = 16'd500;
    localparam logic [TICK_W-1:0] ACTION_DELAY_RST = 16'd1000;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_MENU_ENTER = 3'd1,
        ACT_STREAM     = 3'd2,
        ACT_BANK       = 3'd3,
        ACT_BRIGHT     = 3'd4,
        ACT_LEAVE      = 3'd5
    } action_t;

    // Tap counts that select a menu action
    localparam logic [TAP_W-1:0] TAPS_STREAM = 4'd1;
    localparam logic [TAP_W-1:0] TAPS_BANK   = 4'd2;
    localparam logic [TAP_W-1:0] TAPS_BRIGHT = 4'd3;

    typedef struct packed {
        logic [TICK_W-1:0] long_press;
        logic [TICK_W-1:0] tap_min;
        logic [TICK_W-1:0] tap_max;
        logic [TICK_W-1:0] action_delay;
    } cfg_t;

    typedef struct packed {
        logic [TAP_W-1:0]  taps;
        logic              menu_active;
        logic [BANK_W-1:0] bank;
        action_t           action;
    } result_t;

    function automatic logic [TICK_W-1:0] inc_sat(input logic [TICK_W-1:0] v);
        logic [TICK_W-1:0] r;
        r = (v == TICK_SAT) ? TICK_SAT : v + 1'b1;
        return r;
    endfunction

endpackage

>>> rtl/core/bgd_cfg_regs.sv
// Configuration register file of the button gesture decoder.
// Depends on bgd_pkg for the register indexes and reset values.
module bgd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgd_pkg::TICK_W-1:0]       cfg_data,
    output bgd_pkg::cfg_t                    cfg
);
    import bgd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write; unknown indexes drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:   cfg_next.long_press   = cfg_data;
                CFG_TAP_MIN:      cfg_next.tap_min      = cfg_data;
                CFG_TAP_MAX:      cfg_next.tap_max      = cfg_data;
                CFG_ACTION_DELAY: cfg_next.action_delay = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press   <= LONG_PRESS_RST;
            cfg_reg.tap_min      <= TAP_MIN_RST;
            cfg_reg.tap_max      <= TAP_MAX_RST;
            cfg_reg.action_delay <= ACTION_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/bgd_gesture.sv
// Gesture state and per-tick decision logic of the button gesture decoder.
// Depends on bgd_pkg and button_gesture_decoder_assert.svh.
`include "button_gesture_decoder_assert.svh"

module bgd_gesture (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             down,
    input  bgd_pkg::cfg_t    cfg,
    output bgd_pkg::result_t res
);
    import bgd_pkg::*;

    logic              was_down_reg,   was_down_next;
    logic [TICK_W-1:0] held_ticks_reg, held_ticks_next;
    logic [TICK_W-1:0] idle_ticks_reg, idle_ticks_next;
    logic              in_menu_reg,    in_menu_next;
    logic [TAP_W-1:0]  tap_count_reg,  tap_count_next;
    logic [BANK_W-1:0] bank_sel_reg,   bank_sel_next;
    action_t           action;
    logic [TICK_W-1:0] held_inc;

    assign held_inc = inc_sat(held_ticks_reg);

    always_comb
    begin
        was_down_next   = down;
        held_ticks_next = held_ticks_reg;
        idle_ticks_next = idle_ticks_reg;
        in_menu_next    = in_menu_reg;
        tap_count_next  = tap_count_reg;
        bank_sel_next   = bank_sel_reg;
        action          = ACT_NONE;
        if (down)
        begin
            held_ticks_next = was_down_reg ? held_inc : '0;
            if (!in_menu_reg && held_ticks_next > cfg.long_press)
            begin
                in_menu_next   = 1'b1;
                tap_count_next = '0;
                action         = ACT_MENU_ENTER;
            end
        end
        else
        begin
            if (was_down_reg)
            begin
                held_ticks_next = held_inc;
                if (held_inc < cfg.tap_max && held_inc > cfg.tap_min &&
                    tap_count_reg != TAP_SAT)
                begin
                    tap_count_next = tap_count_reg + 1'b1;
                end
                idle_ticks_next = '0;
            end
            else
            begin
                idle_ticks_next = inc_sat(idle_ticks_reg);
            end
            if (in_menu_reg && idle_ticks_next > cfg.action_delay)
            begin
                case (tap_count_next)
                    TAPS_STREAM: action = ACT_STREAM;
                    TAPS_BANK:
                    begin
                        bank_sel_next = (bank_sel_reg == BANK_LAST) ? '0
                                                                    : bank_sel_reg + 1'b1;
                        action        = ACT_BANK;
                    end
                    TAPS_BRIGHT: action = ACT_BRIGHT;
                    default:     action = ACT_LEAVE;
                endcase
                in_menu_next   = 1'b0;
                tap_count_next = '0;
            end
        end
    end

    assign res.action      = action;
    assign res.bank        = bank_sel_next;
    assign res.menu_active = in_menu_next;
    assign res.taps        = tap_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_down_reg   <= 1'b0;
            held_ticks_reg <= '0;
            idle_ticks_reg <= '0;
            in_menu_reg    <= 1'b0;
            tap_count_reg  <= '0;
            bank_sel_reg   <= BANK_RST;
        end
        else if (step)
        begin
            was_down_reg   <= was_down_next;
            held_ticks_reg <= held_ticks_next;
            idle_ticks_reg <= idle_ticks_next;
            in_menu_reg    <= in_menu_next;
            tap_count_reg  <= tap_count_next;
            bank_sel_reg   <= bank_sel_next;
        end
    end

    `BGD_ASSERT_NOW(a_bank_range, 1'b1, bank_sel_reg != 2'd3, "bank out of range")
    `BGD_ASSERT_NEXT(a_press_edge_clears_held, step && down && !was_down_reg,
                     held_ticks_reg == '0, "held count not cleared on press")
    `BGD_ASSERT_NEXT(a_menu_exit_clears_taps, step && in_menu_reg && !in_menu_next,
                     tap_count_reg == '0 && !in_menu_reg, "menu exit left taps")
    `BGD_ASSERT_NOW(a_action_only_on_menu_change,
                    step && action != ACT_NONE, in_menu_reg != in_menu_next,
                    "action without menu transition")

endmodule

>>> rtl/core/button_gesture_decoder.sv
// Button gesture decoder, top level: stream ports, input and result registers.
// Depends on bgd_pkg, bgd_cfg_regs and bgd_gesture.
//
// Each input item is one time tick carrying the button level in s_tdata[0].
// For every accepted tick the block returns exactly one result item with the
// action taken on that tick, the selected bank, the menu flag and the current
// tap count. A hold longer than long_press_ticks opens the menu; releases with
// a press length strictly between tap_min_ticks and tap_max_ticks count taps
// (saturating at 15); once the menu has seen the button up for more than
// action_delay_ticks, the tap count picks the action and the menu closes.
// Throughput is one tick per clock while m_tready is high: the ticks pass an
// input register, the compare and count logic that also updates the gesture
// state, and a result register. A result is on m_tdata once the result register
// has captured it. A stalled m_tready holds the result register and, through
// it, the input register; s_tready stays high while either of them can advance.
// The configuration channel is always ready; write it only while no tick is
// in flight. Register indexes: 0 long_press_ticks, 1 tap_min_ticks,
// 2 tap_max_ticks, 3 action_delay_ticks; other indexes drop the write.
module button_gesture_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // Tick input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bgd_pkg::IN_DATA_W-1:0]      s_tdata,   // [0] button_down
    // Result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bgd_pkg::OUT_DATA_W-1:0]     m_tdata,   // [2:0] action, [4:3] bank,
                                                          // [5] menu_active, [9:6] taps
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bgd_pkg::TICK_W-1:0]         cfg_data
);
    import bgd_pkg::*;

    cfg_t    cfg;
    result_t res;

    logic    in_valid_reg, in_valid_next;
    logic    in_down_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    out_adv;
    logic    in_adv;
    logic    step;

    bgd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register takes a new item when empty or being drained
    assign out_adv  = !out_valid_reg || m_tready;
    // Process the held tick when the result register can take it
    assign step     = in_valid_reg && out_adv;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;

    bgd_gesture u_gesture (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .down  (in_down_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_comb
    begin
        in_valid_next  = in_adv ? s_tvalid : in_valid_reg;
        out_valid_next = out_adv ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_adv)
        begin
            in_down_reg <= s_tdata[0];
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res_reg};

endmodule

>>> test/tb_button_gesture_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_gesture_decoder: directed gesture runs, then random gestures.
// Depends on bgd_pkg and the button_gesture_decoder RTL; nothing else is read or loaded.
module tb_button_gesture_decoder;

    import bgd_pkg::*;

    // Register indexes outside the list; the block must drop these writes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

    // Random gesture ticks to play after the directed part
    localparam int unsigned RANDOM_TICKS = 1200;

    // One run of ticks at a fixed button level. A pinned row carries the result
    // typed in for its last tick; all other ticks take the decoder model's answer.
    typedef struct {
        logic        level;
        int unsigned len;
        bit          pinned;
        result_t     want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [TICK_W-1:0]     cfg_data;

    // Decoder model state, mirrored from the block's point of view
    cfg_t              cfg_mirror;
    logic              prev_down;
    logic [TICK_W-1:0] hold_len;
    logic [TICK_W-1:0] up_len;
    logic              menu_open;
    logic [TAP_W-1:0]  tap_total;
    logic [BANK_W-1:0] bank_now;

    result_t   want_q[$];
    plan_row_t plan_q[$];

    // Pacing controls: quiet forces full rate on both sides
    bit quiet;
    bit pace_on;
    bit stall_on;

    int unsigned ticks_sent;
    int unsigned results_seen;
    int unsigned n_bad;
    int unsigned n_settings;
    int unsigned act_seen[6];

    button_gesture_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for the slowest correct run of about 1900 ticks, each with random idle
    // gaps on the input side and random stalls on the output.
    initial
    begin
        #2_000_000;
        $display("button_gesture_decoder verification failed");
        $finish;
    end

    function automatic void note_fail(input string msg);
        n_bad++;
        if (n_bad <= 10)
            $display("%s", msg);
    endfunction

    function automatic logic [TICK_W-1:0] sat_bump(input logic [TICK_W-1:0] v);
        return (v == TICK_SAT) ? v : v + 1'b1;
    endfunction

    // Advance the gesture model by one tick and return the result it implies
    function automatic result_t decode_tick(input logic down);
        result_t r;
        r.action = ACT_NONE;
        if (down)
        begin
            // press edge restarts the hold count, later pressed ticks extend it
            hold_len = prev_down ? sat_bump(hold_len) : '0;
            if (!menu_open && hold_len > cfg_mirror.long_press)
            begin
                menu_open = 1'b1;
                tap_total = '0;
                r.action  = ACT_MENU_ENTER;
            end
        end
        else
        begin
            if (prev_down)
            begin
                // release tick: hold_len is now the press length
                hold_len = sat_bump(hold_len);
                if (hold_len < cfg_mirror.tap_max && hold_len > cfg_mirror.tap_min
                    && tap_total != TAP_SAT)
                    tap_total = tap_total + 1'b1;
                up_len = '0;
            end
            else
                up_len = sat_bump(up_len);
            if (menu_open && up_len > cfg_mirror.action_delay)
            begin
                case (tap_total)
                    TAPS_STREAM: r.action = ACT_STREAM;
                    TAPS_BANK:
                    begin
                        bank_now = (bank_now == BANK_LAST) ? '0 : bank_now + 1'b1;
                        r.action = ACT_BANK;
                    end
                    TAPS_BRIGHT: r.action = ACT_BRIGHT;
                    default:     r.action = ACT_LEAVE;
                endcase
                menu_open = 1'b0;
                tap_total = '0;
            end
        end
        prev_down     = down;
        r.bank        = bank_now;
        r.menu_active = menu_open;
        r.taps        = tap_total;
        return r;
    endfunction

    // Press length for one tap: mostly inside the window, sometimes on or past its edges
    function automatic int unsigned press_len();
        int lo;
        int hi;
        int pick;
        lo = int'(cfg_mirror.tap_min) + 1;
        hi = int'(cfg_mirror.tap_max) - 1;
        if (hi >= lo && $urandom_range(0, 3) != 0)
            return $urandom_range(lo, hi);
        case ($urandom_range(0, 4))
            0:       pick = int'(cfg_mirror.tap_min);
            1:       pick = int'(cfg_mirror.tap_max);
            2:       pick = lo;
            3:       pick = hi;
            default: pick = $urandom_range(1, int'(cfg_mirror.tap_max) + 4);
        endcase
        return (pick < 1) ? 1 : pick;
    endfunction

    // Present one tick; on acceptance queue its expected result
    task automatic send_tick(input logic down, input bit pinned, input result_t pinned_res);
        int unsigned gap;
        bit          hit;
        result_t     r;
        gap = (quiet || !pace_on) ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, down};
        do
        begin
            @(negedge clk);
            hit = s_tready;
            if (hit)
            begin
                r = decode_tick(down);
                want_q.push_back(pinned ? pinned_res : r);
            end
            @(posedge clk);
        end
        while (!hit);
        ticks_sent++;
    endtask

    task automatic send_run(input logic level, input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
            send_tick(level, 1'b0, '0);
    endtask

    // Drop valid and wait for every queued result, then idle before returning
    task automatic settle();
        int unsigned w;
        s_tvalid <= 1'b0;
        for (w = 0; want_q.size() != 0 && w < 2000; w++)
            @(posedge clk);
        if (want_q.size() != 0)
        begin
            note_fail($sformatf("%0d results never arrived", want_q.size()));
            want_q.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        bit hit;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            hit = cfg_ready;
            @(posedge clk);
        end
        while (!hit);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_LONG_PRESS:   cfg_mirror.long_press   = val;
            CFG_TAP_MIN:      cfg_mirror.tap_min      = val;
            CFG_TAP_MAX:      cfg_mirror.tap_max      = val;
            CFG_ACTION_DELAY: cfg_mirror.action_delay = val;
            default: ;
        endcase
    endtask

    task automatic load_cfg(input logic [TICK_W-1:0] lp, input logic [TICK_W-1:0] tmin,
                            input logic [TICK_W-1:0] tmax, input logic [TICK_W-1:0] dly);
        settle();
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_TAP_MIN, tmin);
        write_reg(CFG_TAP_MAX, tmax);
        write_reg(CFG_ACTION_DELAY, dly);
        n_settings++;
    endtask

    task automatic plan(input logic level, input int unsigned len, input bit pinned,
                        input action_t act, input int unsigned bank, input bit menu,
                        input int unsigned taps);
        plan_row_t row;
        row.level            = level;
        row.len              = len;
        row.pinned           = pinned;
        row.want.action      = act;
        row.want.bank        = bank[BANK_W-1:0];
        row.want.menu_active = menu;
        row.want.taps        = taps[TAP_W-1:0];
        plan_q.push_back(row);
    endtask

    // Walk the stimulus table in order, then empty it
    task automatic walk_plan();
        int unsigned k;
        foreach (plan_q[n])
            for (k = 0; k < plan_q[n].len; k++)
                send_tick(plan_q[n].level, plan_q[n].pinned && k == plan_q[n].len - 1,
                          plan_q[n].want);
        plan_q.delete();
    endtask

    // One random gesture under the current settings. Most are well-formed menu
    // sessions or tap bursts with random lengths; the rest are line noise,
    // holds one tick too short, and pauses that close the menu early.
    task automatic play_gesture();
        int unsigned kind;
        int unsigned n_taps;
        int unsigned i;
        int unsigned lp;
        int unsigned dly;
        int unsigned gap;
        kind     = $urandom_range(0, 9);
        lp       = 32'(cfg_mirror.long_press);
        dly      = 32'(cfg_mirror.action_delay);
        pace_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        if (kind == 9 || lp > 200 || dly > 200)
        begin
            n_taps = $urandom_range(3, 12);
            for (i = 0; i < n_taps; i++)
                send_run(1'($urandom_range(0, 1)), $urandom_range(1, 4));
        end
        else
        begin
            if (kind < 7)
            begin
                // long press into the menu; now and then one tick too short
                send_run(1'b1, lp + 2 + $urandom_range(0, 3)
                               - (($urandom_range(0, 7) == 0) ? 1 : 0));
                send_run(1'b0, 1 + $urandom_range(0, dly));
                case ($urandom_range(0, 7))
                    0:       n_taps = 0;
                    1:       n_taps = 1;
                    2:       n_taps = 2;
                    3:       n_taps = 3;
                    4:       n_taps = $urandom_range(4, 16);
                    default: n_taps = $urandom_range(1, 3);
                endcase
            end
            else
                n_taps = $urandom_range(1, 17);
            for (i = 0; i < n_taps; i++)
            begin
                send_run(1'b1, press_len());
                // mostly stay inside the action delay; sometimes overrun it
                gap = ($urandom_range(0, 7) == 0) ? dly + 1 + $urandom_range(0, 2)
                                                  : $urandom_range(0, dly);
                send_run(1'b0, 1 + gap);
            end
            if (kind < 7)
                send_run(1'b0, dly + 1 + $urandom_range(0, 3));
        end
    endtask

    // Result side: random stalls, compare every accepted item with the oldest expectation
    initial
    begin : result_sink
        int unsigned stall;
        bit          hit;
        result_t     got;
        result_t     exp_r;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = (quiet || !stall_on) ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                hit = m_tvalid;
                got = m_tdata[$bits(result_t)-1:0];
                if (hit)
                begin
                    results_seen++;
                    if (want_q.size() == 0)
                        note_fail($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                    else
                    begin
                        exp_r = want_q.pop_front();
                        if (got.action != exp_r.action || got.bank != exp_r.bank
                            || got.menu_active != exp_r.menu_active
                            || got.taps != exp_r.taps)
                            note_fail($sformatf({"result %0d: expected action %0d bank %0d",
                                " menu %0b taps %0d, got action %0d bank %0d menu %0b taps %0d"},
                                results_seen, exp_r.action, exp_r.bank, exp_r.menu_active,
                                exp_r.taps, got.action, got.bank, got.menu_active, got.taps));
                        if (got.action <= ACT_LEAVE)
                            act_seen[got.action]++;
                    end
                end
                @(posedge clk);
            end
            while (!hit);
        end
    end

    initial
    begin : stimulus
        int unsigned i;
        int unsigned rand_mark;
        int unsigned phase_mark;
        int unsigned phase_len;
        int unsigned tmin;
        int unsigned tmax;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        pace_on   = 1'b1;
        stall_on  = 1'b1;

        // model starts from the reset state and register defaults
        cfg_mirror.long_press   = LONG_PRESS_RST;
        cfg_mirror.tap_min      = TAP_MIN_RST;
        cfg_mirror.tap_max      = TAP_MAX_RST;
        cfg_mirror.action_delay = ACTION_DELAY_RST;
        prev_down = 1'b0;
        hold_len  = '0;
        up_len    = '0;
        menu_open = 1'b0;
        tap_total = '0;
        bank_now  = BANK_RST;
        n_settings = 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First ticks under the reset settings (hold 1000, taps 50..500, delay 1000)
        plan(1'b0, 1,  1, ACT_NONE, 1, 0, 0);          // first tick after reset
        plan(1'b1, 50, 0, ACT_NONE, 0, 0, 0);
        plan(1'b0, 1,  1, ACT_NONE, 1, 0, 0);          // press equal to the minimum: no tap
        plan(1'b1, 51, 0, ACT_NONE, 0, 0, 0);
        plan(1'b0, 1,  1, ACT_NONE, 1, 0, 1);          // one past the minimum counts
        walk_plan();

        // Short settings for the rest of the table: hold 20, taps 5..15, delay 10
        load_cfg(16'd20, 16'd5, 16'd15, 16'd10);
        plan(1'b1, 14, 0, ACT_NONE, 0, 0, 0);
        plan(1'b0, 1,  1, ACT_NONE, 1, 0, 2);          // one below the maximum counts
        plan(1'b1, 15, 0, ACT_NONE, 0, 0, 0);
        plan(1'b0, 1,  1, ACT_NONE, 1, 0, 2);          // press equal to the maximum: no tap
        plan(1'b1, 21, 1, ACT_NONE, 1, 0, 2);          // hold equal to the long press time
        plan(1'b1, 1,  1, ACT_MENU_ENTER, 1, 1, 0);    // one more tick opens the menu
        plan(1'b1, 6,  1, ACT_NONE, 1, 1, 0);          // long press inside the menu does nothing
        plan(1'b0, 1,  1, ACT_NONE, 1, 1, 0);
        plan(1'b1, 10, 0, ACT_NONE, 0, 0, 0);
        plan(1'b0, 1,  1, ACT_NONE, 1, 1, 1);
        plan(1'b1, 10, 0, ACT_NONE, 0, 0, 0);
        plan(1'b0, 11, 1, ACT_NONE, 1, 1, 2);          // idle equal to the delay: still waiting
        plan(1'b0, 1,  1, ACT_BANK, 2, 0, 0);
        plan(1'b1, 22, 1, ACT_MENU_ENTER, 2, 1, 0);
        plan(1'b0, 12, 1, ACT_LEAVE, 2, 0, 0);         // no taps: just leave
        plan(1'b1, 22, 1, ACT_MENU_ENTER, 2, 1, 0);
        plan(1'b0, 1,  0, ACT_NONE, 0, 0, 0);
        plan(1'b1, 10, 0, ACT_NONE, 0, 0, 0);
        plan(1'b0, 12, 1, ACT_STREAM, 2, 0, 0);
        plan(1'b1, 22, 1, ACT_MENU_ENTER, 2, 1, 0);
        for (i = 0; i < 3; i++)
        begin
            plan(1'b0, 1,  0, ACT_NONE, 0, 0, 0);
            plan(1'b1, 10, 0, ACT_NONE, 0, 0, 0);
        end
        plan(1'b0, 12, 1, ACT_BRIGHT, 2, 0, 0);
        plan(1'b1, 22, 1, ACT_MENU_ENTER, 2, 1, 0);
        for (i = 0; i < 2; i++)
        begin
            plan(1'b0, 1,  0, ACT_NONE, 0, 0, 0);
            plan(1'b1, 10, 0, ACT_NONE, 0, 0, 0);
        end
        plan(1'b0, 12, 1, ACT_BANK, 0, 0, 0);          // bank wraps from the last to zero
        walk_plan();

        // All registers at zero; writes to indexes past the list must be dropped
        load_cfg('0, '0, '0, '0);
        write_reg(CFG_IDX_SPARE, TICK_SAT);
        write_reg(CFG_IDX_TOP, TICK_SAT);
        phase_mark = ticks_sent;
        while (ticks_sent - phase_mark < 150)
            play_gesture();

        // All registers at full scale, at full rate: nothing can ever fire
        load_cfg(TICK_SAT, TICK_SAT, TICK_SAT, TICK_SAT);
        quiet = 1'b1;
        phase_mark = ticks_sent;
        while (ticks_sent - phase_mark < 80)
            play_gesture();
        settle();
        quiet = 1'b0;

        // Random gestures across a series of small settings
        rand_mark = ticks_sent;
        while (ticks_sent - rand_mark < RANDOM_TICKS)
        begin
            tmin = $urandom_range(0, 6);
            tmax = ($urandom_range(0, 5) == 0) ? $urandom_range(0, tmin)
                                               : tmin + $urandom_range(0, 12);
            load_cfg(16'($urandom_range(0, 24)), 16'(tmin), 16'(tmax),
                     16'($urandom_range(0, 20)));
            phase_len  = $urandom_range(250, 350);
            phase_mark = ticks_sent;
            while (ticks_sent - phase_mark < phase_len)
                play_gesture();
        end

        settle();
        repeat (10) @(posedge clk);

        $display("Ran %0d ticks under %0d register settings; %0d results compared.",
                 ticks_sent, n_settings, results_seen);
        $display("Decoded: %0d menu entries, %0d stream, %0d bank, %0d brightness, %0d leave.",
                 act_seen[ACT_MENU_ENTER], act_seen[ACT_STREAM], act_seen[ACT_BANK],
                 act_seen[ACT_BRIGHT], act_seen[ACT_LEAVE]);
        if (n_bad == 0)
            $display("button_gesture_decoder verification clean");
        else
            $display("button_gesture_decoder verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bgd_pkg.sv
rtl/core/bgd_cfg_regs.sv
rtl/core/bgd_gesture.sv
rtl/core/button_gesture_decoder.sv
test/tb_button_gesture_decoder.sv
